/* rtl/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants for the point-in-polygon crossing core
// ----------------------------------------------------------------------------
package pip_pkg;

	// defaults for the top-level parameters
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 16;

	// fixed field widths
	localparam int IDX_WIDTH   = 6;
	localparam int VC_WIDTH    = 7;
	localparam int COUNT_WIDTH = 7;
	localparam int OUT_WIDTH   = 8;

	// vertex count limits and reset value
	localparam int                  MIN_VERTICES = 3;
	localparam logic [VC_WIDTH-1:0] VC_RESET     = 7'd3;

	// item kind carried on s_tuser
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// query sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	// control that travels with one edge into the edge test
	typedef struct packed {
		logic valid;
		logic last;
	} edge_ctl_t;

	// edge test result
	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} edge_res_t;

endpackage

/* rtl/pip_vertex_mem.sv */
// ----------------------------------------------------------------------------
// pip_vertex_mem
// vertex store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pip_vertex_mem #(
	parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
	parameter int DW    = 2 * pip_pkg::COORD_WIDTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/pip_edge_test.sv */
// ----------------------------------------------------------------------------
// pip_edge_test
// two-stage exact edge crossing test for a ray towards +x
// ----------------------------------------------------------------------------
module pip_edge_test #(
	parameter int CW = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pip_pkg::edge_ctl_t  ctl,
	input  logic signed [CW-1:0] x1,
	input  logic signed [CW-1:0] y1,
	input  logic signed [CW-1:0] x2,
	input  logic signed [CW-1:0] y2,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	output pip_pkg::edge_res_t  res
);

	logic signed [CW:0]      dx_edge, dy_edge, dx_pt, dy_pt;
	logic signed [2*CW+1:0]  lhs_d, rhs_d;
	logic                    up_d, span_d, slope_d;

	logic signed [2*CW+1:0]  lhs_s1, rhs_s1;
	logic                    up_s1, span_s1, slope_s1;
	pip_pkg::edge_ctl_t      ctl_s1;
	logic                    hit_d;

	// differences, cross products and y span
	always_comb begin
		dx_edge = $signed({x2[CW-1], x2}) - $signed({x1[CW-1], x1});
		dy_edge = $signed({y2[CW-1], y2}) - $signed({y1[CW-1], y1});
		dx_pt   = $signed({px[CW-1], px}) - $signed({x1[CW-1], x1});
		dy_pt   = $signed({py[CW-1], py}) - $signed({y1[CW-1], y1});
		lhs_d   = dy_pt * dx_edge;
		rhs_d   = dx_pt * dy_edge;
		up_d    = y2 > y1;
		slope_d = y2 != y1;
		if (up_d) begin
			span_d = (py >= y1) && (py <= y2);
		end else begin
			span_d = (py >= y2) && (py <= y1);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		lhs_s1   <= lhs_d;
		rhs_s1   <= rhs_d;
		up_s1    <= up_d;
		span_s1  <= span_d;
		slope_s1 <= slope_d;
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	// compare with the sign of dy folded in
	always_comb begin
		if (up_s1) begin
			hit_d = slope_s1 && span_s1 && (lhs_s1 > rhs_s1);
		end else begin
			hit_d = slope_s1 && span_s1 && (lhs_s1 < rhs_s1);
		end
	end

	// stage 2 result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
		end else begin
			res.valid <= ctl_s1.valid;
			res.last  <= ctl_s1.last;
			res.hit   <= hit_d;
		end
	end

endmodule

/* rtl/point_in_polygon_crossing_core.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_core
// stored polygon with a ray-crossing inside test for query points
// ----------------------------------------------------------------------------
// A write word stores one vertex and gives no result. A query
// word walks the polygon's n = vertex_count vertices (clamped to 3..MAX_VERTICES)
// one vertex store read per cycle, vertex 0 read again at the end to close the
// polygon; the vertex store has a single read port. No new word is taken until
// the result word has been loaded into the output register. Edges are tested
// in a two-stage pipeline with exact cross products, horizontal edges are
// skipped and the y span of an edge counts inclusively at both ends. The next
// word is taken while a finished result still waits on the output. Reading a
// vertex slot that was never written gives an unspecified result.
module point_in_polygon_crossing_core #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
	localparam int S_TDATA_W   = ((pip_pkg::IDX_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: vertex_count
	input  logic                          cfg_we,
	input  logic [pip_pkg::VC_WIDTH-1:0]  cfg_wdata,
	// input words
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [S_TDATA_W-1:0]          s_tdata,  // vertex_index, point_x, point_y
	input  logic [0:0]                    s_tuser,  // command
	// result words
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pip_pkg::OUT_WIDTH-1:0] m_tdata   // inside_res, crossings
);

	localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CW    = COORD_WIDTH;
	localparam int IW    = pip_pkg::IDX_WIDTH;

	pip_pkg::state_t                  state_q, state_d;
	logic [pip_pkg::VC_WIDTH-1:0]     vc_q;
	logic [CNT_W-1:0]                 n_d, n_q, rd_cnt_q;
	logic [IW-1:0]                    in_idx;
	logic signed [CW-1:0]             in_x, in_y, px_q, py_q;
	logic [31:0]                      idx_ext;
	logic                             accept, mem_we, rd_en, rd_last, out_load;
	logic [AW-1:0]                    waddr, raddr;
	logic [2*CW-1:0]                  rdata;
	logic                             rd_valid_s1, rd_last_s1, first_q;
	logic signed [CW-1:0]             prev_x_q, prev_y_q;
	pip_pkg::edge_ctl_t               ectl;
	pip_pkg::edge_res_t               eres;
	logic [pip_pkg::COUNT_WIDTH-1:0]  cnt_q;
	logic                             m_tvalid_q;
	logic [pip_pkg::OUT_WIDTH-1:0]    m_tdata_q;

	// input field unpacking
	assign in_idx  = s_tdata[IW-1:0];
	assign in_x    = s_tdata[IW+CW-1:IW];
	assign in_y    = s_tdata[IW+2*CW-1:IW+CW];
	assign idx_ext = 32'(in_idx);
	assign waddr   = idx_ext[AW-1:0];

	assign accept = s_tvalid && s_tready;
	assign mem_we = accept && (pip_pkg::cmd_t'(s_tuser[0]) == pip_pkg::CMD_WRITE)
		&& (int'(in_idx) < MAX_VERTICES);

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= pip_pkg::VC_RESET;
		end else if (cfg_we) begin
			vc_q <= cfg_wdata;
		end
	end

	// clamp vertex count to the legal range
	always_comb begin
		if (int'(vc_q) < pip_pkg::MIN_VERTICES) begin
			n_d = CNT_W'(pip_pkg::MIN_VERTICES);
		end else if (int'(vc_q) > MAX_VERTICES) begin
			n_d = CNT_W'(MAX_VERTICES);
		end else begin
			n_d = CNT_W'(vc_q);
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pip_pkg::ST_IDLE: begin
				if (accept && (pip_pkg::cmd_t'(s_tuser[0]) == pip_pkg::CMD_QUERY)) begin
					state_d = pip_pkg::ST_WALK;
				end
			end
			pip_pkg::ST_WALK: begin
				if (rd_last) begin
					state_d = pip_pkg::ST_DRAIN;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (eres.valid && eres.last) begin
					state_d = pip_pkg::ST_HOLD;
				end
			end
			pip_pkg::ST_HOLD: begin
				if (out_load) begin
					state_d = pip_pkg::ST_IDLE;
				end
			end
			default: state_d = pip_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			pip_pkg::ST_IDLE:  s_tready = 1'b1;
			pip_pkg::ST_WALK:  rd_en    = 1'b1;
			pip_pkg::ST_DRAIN: ;
			pip_pkg::ST_HOLD:  out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	assign rd_last = rd_en && (rd_cnt_q == n_q);
	assign raddr   = (rd_cnt_q == n_q) ? '0 : rd_cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// query point and walk length, latched at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= in_x;
			py_q <= in_y;
			n_q  <= n_d;
		end
	end

	// read address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
		end else if (accept) begin
			rd_cnt_q <= '0;
		end else if (rd_en) begin
			rd_cnt_q <= rd_cnt_q + CNT_W'(1);
		end
	end

	pip_vertex_mem #(
		.DEPTH (MAX_VERTICES),
		.DW    (2 * CW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata ({in_y, in_x}),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// read data tracking and previous vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			rd_last_s1  <= rd_last;
			if (accept) begin
				first_q <= 1'b1;
			end else if (rd_valid_s1) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			prev_x_q <= rdata[CW-1:0];
			prev_y_q <= rdata[2*CW-1:CW];
		end
	end

	assign ectl.valid = rd_valid_s1 && !first_q;
	assign ectl.last  = rd_last_s1;

	pip_edge_test #(
		.CW (CW)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ectl),
		.x1     (prev_x_q),
		.y1     (prev_y_q),
		.x2     (rdata[CW-1:0]),
		.y2     (rdata[2*CW-1:CW]),
		.px     (px_q),
		.py     (py_q),
		.res    (eres)
	);

	// crossing counter, wraps modulo 128
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (eres.valid) begin
			cnt_q <= cnt_q + {{(pip_pkg::COUNT_WIDTH-1){1'b0}}, eres.hit};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {cnt_q, cnt_q[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// no read during a vertex write
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("vertex store read and write in the same cycle");

	// a query starts the walk in the next cycle
	a_query_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (pip_pkg::cmd_t'(s_tuser[0]) == pip_pkg::CMD_QUERY))
		|=> (state_q == pip_pkg::ST_WALK))
		else $error("query accepted without starting the walk");

	// edge results only arrive during a query
	a_res_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		eres.valid |-> (state_q == pip_pkg::ST_WALK || state_q == pip_pkg::ST_DRAIN))
		else $error("edge result outside a query");

	// a result word is loaded only at the end of a query
	a_load_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(eres.valid && eres.last) |=> (state_q == pip_pkg::ST_HOLD))
		else $error("last edge did not finish the query");

endmodule
